// File: src/swrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swrm_pkg
// shared constants and types for the sliding window rate meter
// ----------------------------------------------------------------------------
package swrm_pkg;
	localparam int unsigned TableDepth = 64;
	localparam int unsigned AddrW = $clog2(TableDepth);
	localparam int unsigned CntW = $clog2(TableDepth + 1);
	localparam int unsigned StampW = 52;
	localparam int unsigned BytesW = 32;
	localparam int unsigned SumW = BytesW + AddrW;
	localparam int unsigned NumW = SumW + 20;
	localparam int unsigned SpanW = 53;
	localparam logic [19:0] UsecPerSec = 20'd1000000;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_EXPIRE = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN_RD, ST_SCAN, ST_SHIFT_RD, ST_SHIFT_WR, ST_EXP_RD, ST_EXP,
		ST_SUM_RD, ST_SUM, ST_SPAN, ST_MUL, ST_DIV, ST_OUT
	} state_t;

	typedef struct packed {
		logic          start;
		logic [NumW-1:0] num;
		logic [SpanW-1:0] den;
	} div_req_t;
endpackage
`default_nettype wire

// File: src/swrm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swrm_div
// restoring divider, one quotient bit per cycle, result saturated to 32 bits
// ----------------------------------------------------------------------------
module swrm_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire swrm_pkg::div_req_t  req,
	output logic                     done,
	output logic [31:0]              quot
);
	import swrm_pkg::*;
	localparam int unsigned IdxW = $clog2(NumW + 1);

	logic [NumW-1:0]  num_q;
	logic [NumW-1:0]  q_q;
	logic [SpanW:0]   rem_q;
	logic [SpanW-1:0] den_q;
	logic [IdxW-1:0]  cnt_q;
	logic             busy_q;
	logic [SpanW:0]   trial;
	logic [SpanW:0]   diff;

	assign trial = {rem_q[SpanW-1:0], num_q[NumW-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= IdxW'(NumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == IdxW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NumW-2:0], 1'b0};
			if (!diff[SpanW]) begin
				rem_q <= diff;
				q_q   <= {q_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q   <= {q_q[NumW-2:0], 1'b0};
			end
		end
	end

	assign quot = (|q_q[NumW-1:32]) ? 32'hFFFF_FFFF : q_q[31:0];
endmodule
`default_nettype wire

// File: src/sliding_window_rate_meter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_rate_meter_core
// time-sorted sample table in block memory with a windowed byte rate output
// ----------------------------------------------------------------------------
// one request at a time; the next is taken once the response has left
// an insert scans for its place and shifts the entries behind it, the sum reads each
// entry once, and the divider then works out the rate
// one memory read port and one write port set the walk rates
// reset clears the count and control; table contents are undefined until written
module sliding_window_rate_meter_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// command[1:0], time_sec[33:2], time_usec[53:34], quantity[85:54], zero[87:86]
	input  wire logic [87:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// byte_rate[31:0], entry_count[38:32], dropped[39]
	output logic [39:0]      m_tdata
);
	import swrm_pkg::*;

	localparam int unsigned EntW = StampW + BytesW;

	logic [EntW-1:0] mem [TableDepth];
	logic [EntW-1:0] rd_data;
	logic [AddrW-1:0] rd_addr, wr_addr;
	logic [EntW-1:0] wr_data;
	logic rd_en, wr_en;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data <= mem[rd_addr];
	end

	state_t state_q, state_d;
	logic [StampW-1:0] stamp_q;
	logic [BytesW-1:0] bytes_q;
	logic [CntW-1:0]   cnt_q, cnt_d;
	logic [CntW-1:0]   idx_q, idx_d;
	logic [CntW-1:0]   pos_q, pos_d;
	logic              drop_q, drop_d;
	logic [SumW-1:0]   sum_q, sum_d;
	logic [StampW-1:0] newest_q, newest_d;
	logic [SpanW-1:0]  span_q, span_d;
	logic              spanok_q, spanok_d;
	logic [NumW-1:0]   num_q, num_d;
	logic [31:0]       rate_q, rate_d;
	logic              ovalid_d;
	logic              div_done;
	logic [31:0]       div_quot;
	div_req_t          dreq;
	logic [StampW-1:0] rd_stamp;
	logic [BytesW-1:0] rd_bytes;
	logic signed [SpanW:0] sdiff;
	logic signed [SpanW+1:0] span_full;

	assign rd_stamp = rd_data[EntW-1:BytesW];
	assign rd_bytes = rd_data[BytesW-1:0];
	assign sdiff = $signed({22'b0, newest_q[StampW-1:20]})
		- $signed({22'b0, rd_stamp[StampW-1:20]});
	assign span_full = (SpanW+2)'(sdiff * $signed((SpanW+1)'(UsecPerSec)))
		+ $signed((SpanW+2)'(newest_q[19:0])) - $signed((SpanW+2)'(rd_stamp[19:0]));

	swrm_div u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq), .done(div_done), .quot(div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (ovalid_d) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d; pos_q <= pos_d; drop_q <= drop_d; sum_q <= sum_d;
		newest_q <= newest_d; span_q <= span_d; spanok_q <= spanok_d;
		num_q <= num_d; rate_q <= rate_d;
		if (s_tvalid && s_tready) begin
			stamp_q <= {s_tdata[33:2], s_tdata[53:34]};
			bytes_q <= s_tdata[85:54];
		end
		if (ovalid_d) m_tdata <= {drop_q, 7'(cnt_q), rate_d};
	end

	assign s_tready = (state_q == ST_IDLE) && !m_tvalid;

	always_comb begin
		state_d = state_q; cnt_d = cnt_q; idx_d = idx_q; pos_d = pos_q;
		drop_d = drop_q; sum_d = sum_q; newest_d = newest_q; span_d = span_q;
		spanok_d = spanok_q; num_d = num_q; rate_d = rate_q; ovalid_d = 1'b0;
		rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; wr_addr = '0; wr_data = '0;
		dreq = '{start: 1'b0, num: num_q, den: span_q};
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && s_tready) begin
					drop_d = 1'b0;
					unique case (cmd_t'(s_tdata[1:0]))
						CMD_INSERT: begin
							if (cnt_q >= CntW'(TableDepth)) begin
								cnt_d = CntW'(TableDepth - 1);
								drop_d = 1'b1;
							end
							pos_d = '0;
							state_d = ST_SCAN_RD;
						end
						CMD_EXPIRE: state_d = ST_EXP_RD;
						CMD_CLEAR: begin
							cnt_d = '0;
							state_d = ST_SUM_RD;
						end
						default: state_d = ST_SUM_RD;
					endcase
				end
			end
			ST_SCAN_RD: begin
				if (pos_q < cnt_q) begin
					rd_en = 1'b1; rd_addr = pos_q[AddrW-1:0];
					state_d = ST_SCAN;
				end else begin
					idx_d = cnt_q; state_d = ST_SHIFT_RD;
				end
			end
			ST_SCAN: begin
				if (rd_stamp >= stamp_q) begin
					pos_d = pos_q + 1'b1; state_d = ST_SCAN_RD;
				end else begin
					idx_d = cnt_q; state_d = ST_SHIFT_RD;
				end
			end
			ST_SHIFT_RD: begin
				if (idx_q > pos_q) begin
					rd_en = 1'b1; rd_addr = AddrW'(idx_q - 1'b1);
					state_d = ST_SHIFT_WR;
				end else begin
					wr_en = 1'b1; wr_addr = pos_q[AddrW-1:0];
					wr_data = {stamp_q, bytes_q};
					cnt_d = cnt_q + 1'b1;
					state_d = ST_SUM_RD;
				end
			end
			ST_SHIFT_WR: begin
				wr_en = 1'b1; wr_addr = idx_q[AddrW-1:0]; wr_data = rd_data;
				idx_d = idx_q - 1'b1; state_d = ST_SHIFT_RD;
			end
			ST_EXP_RD: begin
				if (cnt_q != '0) begin
					rd_en = 1'b1; rd_addr = AddrW'(cnt_q - 1'b1);
					state_d = ST_EXP;
				end else state_d = ST_SUM_RD;
			end
			ST_EXP: begin
				if (rd_stamp < stamp_q) begin
					cnt_d = cnt_q - 1'b1; state_d = ST_EXP_RD;
				end else state_d = ST_SUM_RD;
			end
			ST_SUM_RD: begin
				if (cnt_q < CntW'(2)) begin
					rate_d = '0; ovalid_d = 1'b1; state_d = ST_IDLE;
				end else begin
					idx_d = '0; sum_d = '0;
					rd_en = 1'b1; rd_addr = '0;
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				if (idx_q == '0) newest_d = rd_stamp;
				if (idx_q + 1'b1 < cnt_q) begin
					sum_d = sum_q + SumW'(rd_bytes);
					idx_d = idx_q + 1'b1;
					rd_en = 1'b1; rd_addr = AddrW'(idx_q + 1'b1);
				end else state_d = ST_SPAN;
			end
			ST_SPAN: begin
				spanok_d = (span_full > 0);
				span_d = SpanW'(span_full);
				state_d = ST_MUL;
			end
			ST_MUL: begin
				num_d = NumW'(sum_q) * NumW'(UsecPerSec);
				if (!spanok_q) begin
					rate_d = '0; ovalid_d = 1'b1; state_d = ST_IDLE;
				end else state_d = ST_DIV;
				dreq.start = spanok_q;
				dreq.num = NumW'(sum_q) * NumW'(UsecPerSec);
			end
			ST_DIV: begin
				if (div_done) begin
					rate_d = div_quot; ovalid_d = 1'b1; state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	ap_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready) else $error("accept while busy");
	ap_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(TableDepth)) else $error("count overflow");
	ap_out_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) != ST_IDLE) else $error("spurious result");
endmodule
`default_nettype wire

// File: tb/sliding_window_rate_meter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_rate_meter_core_tb
// drives insert, expire, clear and no-op requests into the rate meter, first from a
// table of directed rows and then as mostly time-ordered random traffic that
// fills, overflows and ages the table; every response is compared with a fixed
// row value or a local model of the sorted table and its windowed byte rate
// ----------------------------------------------------------------------------
module sliding_window_rate_meter_core_tb;
	import swrm_pkg::*;

	localparam int CycleLimit = 2000000;
	localparam int RandomItems = 1020;
	localparam int DrainCycles = 400;

	typedef struct {
		cmd_t        cmd;
		logic [31:0] sec;
		logic [19:0] usec;
		logic [31:0] qty;
	} meter_req_t;

	typedef struct {
		logic [31:0] rate;
		logic [6:0]  count;
		logic        drop;
	} meter_resp_t;

	typedef struct {
		meter_req_t  req;
		logic        fixed;
		meter_resp_t resp;
	} table_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// command[1:0], time_sec[33:2], time_usec[53:34], quantity[85:54], zero[87:86]
	logic [87:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	// byte_rate[31:0], entry_count[38:32], dropped[39]
	logic [39:0] m_tdata;

	logic [51:0] model_stamp [TableDepth];
	logic [31:0] model_bytes [TableDepth];
	int          model_held;

	meter_resp_t resp_q[$];
	table_row_t  rows[$];
	int          idle_pct;
	int          stall_pct;
	int          fail_count;
	int          cycle_count;
	int          sent_count;
	int          checked_count;
	int          drop_count;
	int          sat_count;
	int          peak_held;
	logic [31:0] base_sec;

	sliding_window_rate_meter_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic meter_resp_t meter_step(input meter_req_t r);
		meter_resp_t res;
		logic [51:0] stamp;
		logic [127:0] sum;
		logic [127:0] quot;
		longint span;
		int pos;
		stamp = {r.sec, r.usec};
		res.drop = 1'b0;
		if (r.cmd == CMD_INSERT) begin
			if (model_held >= TableDepth) begin
				model_held = TableDepth - 1;
				res.drop = 1'b1;
			end
			pos = 0;
			while (pos < model_held && model_stamp[pos] >= stamp)
				pos++;
			for (int k = model_held; k > pos; k--) begin
				model_stamp[k] = model_stamp[k-1];
				model_bytes[k] = model_bytes[k-1];
			end
			model_stamp[pos] = stamp;
			model_bytes[pos] = r.qty;
			model_held++;
		end else if (r.cmd == CMD_EXPIRE) begin
			while (model_held > 0 && model_stamp[model_held-1] < stamp)
				model_held--;
		end else if (r.cmd == CMD_CLEAR) begin
			model_held = 0;
		end
		res.rate = '0;
		if (model_held >= 2) begin
			sum = '0;
			for (int k = 0; k + 1 < model_held; k++)
				sum += model_bytes[k];
			span = (longint'(model_stamp[0][51:20]) - longint'(model_stamp[model_held-1][51:20]))
				* 1000000 + (longint'(model_stamp[0][19:0])
				- longint'(model_stamp[model_held-1][19:0]));
			if (span > 0) begin
				quot = (sum * 128'd1000000) / 128'(span);
				res.rate = (quot > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
			end
		end
		res.count = 7'(model_held);
		return res;
	endfunction

	function automatic void add_row(input cmd_t c, input logic [31:0] s, input logic [19:0] u,
			input logic [31:0] q, input logic fx, input logic [31:0] rt, input int n,
			input logic d);
		table_row_t row;
		row.req = '{c, s, u, q};
		row.fixed = fx;
		row.resp = '{rt, 7'(n), d};
		rows.push_back(row);
	endfunction

	function automatic meter_req_t random_req();
		meter_req_t r;
		int pick;
		pick = $urandom_range(99);
		r.qty = 32'($urandom_range(0, 5000));
		r.usec = 20'($urandom_range(0, 999999));
		if (pick < 3) begin
			r.cmd = cmd_t'($urandom_range(0, 3));
			r.sec = $urandom;
			r.usec = 20'($urandom);
			r.qty = $urandom;
		end else if (pick < 5) begin
			r.cmd = CMD_CLEAR;
			r.sec = $urandom;
			base_sec = $urandom;
		end else if (pick < 15) begin
			r.cmd = CMD_EXPIRE;
			r.sec = base_sec - 32'($urandom_range(0, 12));
		end else begin
			r.cmd = CMD_INSERT;
			r.sec = base_sec - (($urandom_range(3) == 0) ? 32'($urandom_range(0, 3)) : 32'd0);
			base_sec += 32'($urandom_range(0, 1));
			case ($urandom_range(3))
				0: r.qty = $urandom;
				1: r.qty = 32'hFFFF_FFFF;
				default: ;
			endcase
		end
		return r;
	endfunction

	task automatic send_req(input meter_req_t r, input logic fx, input meter_resp_t fixed_resp);
		meter_resp_t pred;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, r.qty, r.usec, r.sec, r.cmd};
		do
			@(posedge clk);
		while (!s_tready);
		pred = meter_step(r);
		resp_q.push_back(fx ? fixed_resp : pred);
		sent_count++;
		if (model_held > peak_held)
			peak_held = model_held;
		if (pred.drop)
			drop_count++;
		if (model_held >= 2 && pred.rate == 32'hFFFF_FFFF)
			sat_count++;
		@(negedge clk);
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		meter_resp_t want;
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("sliding_window_rate_meter_core_tb failed");
			$finish;
		end
		if (m_tvalid && m_tready) begin
			if (resp_q.size() == 0) begin
				$error("response with no request outstanding: %h", m_tdata);
				fail_count++;
			end else begin
				want = resp_q.pop_front();
				checked_count++;
				if (m_tdata[31:0] !== want.rate) begin
					$error("byte_rate expected %0d got %0d", want.rate, m_tdata[31:0]);
					fail_count++;
				end
				if (m_tdata[38:32] !== want.count) begin
					$error("entry_count expected %0d got %0d", want.count, m_tdata[38:32]);
					fail_count++;
				end
				if (m_tdata[39] !== want.drop) begin
					$error("dropped expected %0d got %0d", want.drop, m_tdata[39]);
					fail_count++;
				end
			end
		end
	end

	initial begin
		meter_resp_t none;
		none = '{'0, '0, 1'b0};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		fail_count = 0;
		cycle_count = 0;
		sent_count = 0;
		checked_count = 0;
		drop_count = 0;
		sat_count = 0;
		peak_held = 0;
		model_held = 0;
		base_sec = $urandom;

		// after reset, extremes, ordering of equal stamps, odd microseconds
		add_row(CMD_CLEAR, 0, 0, 0, 1, 0, 0, 0);
		add_row(CMD_EXPIRE, 32'hFFFF_FFFF, 20'hF_FFFF, 0, 1, 0, 0, 0);
		add_row(CMD_INSERT, 0, 0, 32'hFFFF_FFFF, 1, 0, 1, 0);
		add_row(CMD_INSERT, 1, 0, 1000, 1, 1000, 2, 0);
		add_row(CMD_INSERT, 1, 0, 5, 0, 0, 0, 0);
		add_row(CMD_INSERT, 32'hFFFF_FFFF, 999999, 32'hFFFF_FFFF, 0, 0, 0, 0);
		add_row(CMD_NONE, 32'hFFFF_FFFF, 20'hF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0);
		add_row(CMD_INSERT, 32'hFFFF_FFFF, 20'hF_FFFF, 7, 0, 0, 0, 0);
		add_row(CMD_INSERT, 0, 20'hF_FFFF, 9, 0, 0, 0, 0);
		add_row(CMD_EXPIRE, 1, 0, 0, 0, 0, 0, 0);
		add_row(CMD_EXPIRE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
		add_row(CMD_CLEAR, 32'hFFFF_FFFF, 20'hF_FFFF, 32'hFFFF_FFFF, 1, 0, 0, 0);
		add_row(CMD_INSERT, 5, 0, 10, 1, 0, 1, 0);
		add_row(CMD_INSERT, 5, 0, 20, 1, 0, 2, 0);
		add_row(CMD_INSERT, 5, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 3, 0);
		add_row(CMD_INSERT, 4, 999999, 3, 0, 0, 0, 0);
		add_row(CMD_EXPIRE, 5, 0, 0, 0, 0, 0, 0);
		add_row(CMD_EXPIRE, 5, 1, 0, 1, 0, 1, 0);
		add_row(CMD_CLEAR, 0, 0, 0, 1, 0, 0, 0);
		// one second apart, equal sizes: fill the table and overflow it twice
		for (int i = 0; i < 66; i++)
			add_row(CMD_INSERT, 32'(100 + i), 0, 1000, 1, (i == 0) ? 32'd0 : 32'd1000,
				(i < 64) ? i + 1 : 64, (i >= 64) ? 1'b1 : 1'b0);
		add_row(CMD_INSERT, 50, 0, 7, 0, 0, 0, 0);
		add_row(CMD_CLEAR, 0, 0, 0, 1, 0, 0, 0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i])
			send_req(rows[i].req, rows[i].fixed, rows[i].resp);

		for (int n = 0; n < RandomItems; n++) begin
			case (n)
				0: begin idle_pct = 0; stall_pct = 0; end
				275: begin idle_pct = 69; stall_pct = 0; end
				550: begin idle_pct = 0; stall_pct = 69; end
				825: begin idle_pct = 36; stall_pct = 36; end
				default: ;
			endcase
			// hold off until the pipeline has fully drained
			if (n == 400) begin
				s_tvalid <= 1'b0;
				while (resp_q.size() != 0)
					@(negedge clk);
			end
			send_req(random_req(), 1'b0, none);
			// stretches with no idling inside the last phase
			if (n >= 825 && n % 60 == 0) begin
				idle_pct = (idle_pct == 0) ? 36 : 0;
				stall_pct = idle_pct;
			end
		end
		s_tvalid <= 1'b0;

		while (resp_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("covered %0d requests, %0d responses checked, peak occupancy %0d",
			sent_count, checked_count, peak_held);
		$display("overflow drops %0d, saturated rates %0d", drop_count, sat_count);
		if (fail_count == 0)
			$display("sliding_window_rate_meter_core_tb passed");
		else
			$display("sliding_window_rate_meter_core_tb failed");
		$finish;
	end
endmodule

// File: sim.f
src/swrm_pkg.sv
src/swrm_div.sv
src/sliding_window_rate_meter_core.sv
tb/sliding_window_rate_meter_core_tb.sv
